// ===== rtl/ast_pkg.sv =====
// Shared types and constants for the alarm slot table.
package ast_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int IDX_W  = 8;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        CMD_ARM     = 2'd0,
        CMD_REWRITE = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_ARM_BAD = 2'd1,
        OP_WRITE   = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    localparam logic KIND_ARM  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    // queued request; tval holds the trigger time or, for a tick, the current time
    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] tval;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] idx;
    } t_req;

    typedef struct packed {
        logic              kind;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } t_rsp;

endpackage

// ===== rtl/ast_if.sv =====
// Request and response channel interfaces of the alarm slot table.
interface ast_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [ast_pkg::TIME_W-1:0] trigger_time;
    logic [ast_pkg::TAG_W-1:0]  event_tag;
    logic [ast_pkg::IDX_W-1:0]  slot_index;
    logic [ast_pkg::TIME_W-1:0] now_time;

    modport source (output valid, cmd, trigger_time, event_tag, slot_index, now_time,
                    input ready);
    modport sink   (input valid, cmd, trigger_time, event_tag, slot_index, now_time,
                    output ready);
endinterface

interface ast_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [1:0]                 status;
    logic [ast_pkg::SLOT_W-1:0] slot;
    logic [ast_pkg::TAG_W-1:0]  tag_out;
    logic                       last;

    modport source (output valid, kind, status, slot, tag_out, last, input ready);
    modport sink   (input valid, kind, status, slot, tag_out, last, output ready);
endinterface

// ===== rtl/ast_front.sv =====
// Front end: accepts requests, classifies them and pushes work into the queue.
module ast_front #(
    parameter int SLOT_COUNT = 10
) (
    ast_req_if.sink          i_req,
    input  logic             i_full,
    output logic             o_push,
    output ast_pkg::t_req    o_push_data
);

    logic accept;
    logic zero_arg;
    logic idx_ok;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign zero_arg    = (i_req.trigger_time == '0) || (i_req.event_tag == '0);
    assign idx_ok      = i_req.slot_index < ast_pkg::IDX_W'(SLOT_COUNT);

    always_comb begin
        o_push           = 1'b0;
        o_push_data.op   = ast_pkg::OP_ARM;
        o_push_data.tval = i_req.trigger_time;
        o_push_data.tag  = i_req.event_tag;
        o_push_data.idx  = i_req.slot_index[ast_pkg::SLOT_W-1:0];
        case (i_req.cmd)
            ast_pkg::CMD_ARM: begin
                o_push         = accept;
                o_push_data.op = zero_arg ? ast_pkg::OP_ARM_BAD : ast_pkg::OP_ARM;
            end
            ast_pkg::CMD_REWRITE: begin
                o_push         = accept && !zero_arg && idx_ok;
                o_push_data.op = ast_pkg::OP_WRITE;
            end
            ast_pkg::CMD_TICK: begin
                o_push           = accept;
                o_push_data.op   = ast_pkg::OP_TICK;
                o_push_data.tval = i_req.now_time;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ast_queue.sv =====
// Two-entry queue of classified requests between front and back.
module ast_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ast_pkg::t_req i_data,
    output ast_pkg::t_req o_data,
    input  logic          i_push,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_vld
);

    ast_pkg::t_req r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== rtl/ast_back.sv =====
// Back end: slot table, slot scan sequencer and response register.
module ast_back #(
    parameter int SLOT_COUNT = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    input  ast_pkg::t_req i_q_data,
    output logic          o_q_pop,
    ast_rsp_if.source     o_rsp
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ARM  = 4'b0010,
        S_TICK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    ast_pkg::t_req r_req, n_req;
    ast_pkg::t_rsp r_out, n_out;
    logic          r_out_vld, n_out_vld;
    ast_pkg::t_rsp r_pend, n_pend;
    logic          r_pend_vld, n_pend_vld;

    logic [ast_pkg::TIME_W-1:0] r_time [SLOT_COUNT];
    logic [ast_pkg::TAG_W-1:0]  r_tag  [SLOT_COUNT];

    logic                       tbl_we;
    logic [IW-1:0]              tbl_widx;
    logic [ast_pkg::TIME_W-1:0] tbl_wtime;
    logic [ast_pkg::TAG_W-1:0]  tbl_wtag;

    logic [ast_pkg::TIME_W-1:0] cur_time;
    logic                       can_emit;
    logic                       hit;
    ast_pkg::t_rsp              fire_rsp;

    assign cur_time = r_time[r_idx];
    assign can_emit = !r_out_vld || o_rsp.ready;
    assign hit      = (cur_time != '0) && (cur_time == r_req.tval);

    always_comb begin
        fire_rsp.kind   = ast_pkg::KIND_FIRE;
        fire_rsp.status = ast_pkg::ST_OK;
        fire_rsp.slot   = ast_pkg::SLOT_W'(r_idx);
        fire_rsp.tag    = r_tag[r_idx];
        fire_rsp.last   = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_req      = r_req;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        o_q_pop    = 1'b0;
        tbl_we     = 1'b0;
        tbl_widx   = r_idx;
        tbl_wtime  = r_req.tval;
        tbl_wtag   = r_req.tag;

        if (r_out_vld && o_rsp.ready) n_out_vld = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    n_req = i_q_data;
                    n_idx = '0;
                    case (i_q_data.op)
                        ast_pkg::OP_ARM_BAD: begin
                            if (can_emit) begin
                                o_q_pop      = 1'b1;
                                n_out.kind   = ast_pkg::KIND_ARM;
                                n_out.status = ast_pkg::ST_INVALID;
                                n_out.slot   = '0;
                                n_out.tag    = '0;
                                n_out.last   = 1'b1;
                                n_out_vld    = 1'b1;
                            end
                        end
                        ast_pkg::OP_WRITE: begin
                            o_q_pop   = 1'b1;
                            tbl_we    = 1'b1;
                            tbl_widx  = i_q_data.idx[IW-1:0];
                            tbl_wtime = i_q_data.tval;
                            tbl_wtag  = i_q_data.tag;
                        end
                        ast_pkg::OP_ARM: begin
                            o_q_pop = 1'b1;
                            n_state = S_ARM;
                        end
                        ast_pkg::OP_TICK: begin
                            o_q_pop = 1'b1;
                            n_state = S_TICK;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_ARM: begin
                if (cur_time == '0) begin
                    if (can_emit) begin
                        tbl_we       = 1'b1;
                        n_out.kind   = ast_pkg::KIND_ARM;
                        n_out.status = ast_pkg::ST_OK;
                        n_out.slot   = ast_pkg::SLOT_W'(r_idx);
                        n_out.tag    = '0;
                        n_out.last   = 1'b1;
                        n_out_vld    = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (can_emit) begin
                        n_out.kind   = ast_pkg::KIND_ARM;
                        n_out.status = ast_pkg::ST_FULL;
                        n_out.slot   = '0;
                        n_out.tag    = '0;
                        n_out.last   = 1'b1;
                        n_out_vld    = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TICK: begin
                if (hit && r_pend_vld && !can_emit) begin
                    n_state = S_TICK;
                end else begin
                    if (hit) begin
                        // hold the newest fire back until we know whether it is the last
                        if (r_pend_vld) begin
                            n_out     = r_pend;
                            n_out_vld = 1'b1;
                        end
                        n_pend     = fire_rsp;
                        n_pend_vld = 1'b1;
                        tbl_we     = 1'b1;
                        tbl_wtime  = '0;
                        tbl_wtag   = r_tag[r_idx];
                    end
                    if (r_idx == LAST_IDX) n_state = S_DONE;
                    else                   n_idx   = r_idx + IW'(1);
                end
            end
            S_DONE: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (can_emit) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_time[i] <= '0;
                r_tag[i]  <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            if (tbl_we) begin
                r_time[tbl_widx] <= tbl_wtime;
                r_tag[tbl_widx]  <= tbl_wtag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_req  <= n_req;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.kind    = r_out.kind;
    assign o_rsp.status  = r_out.status;
    assign o_rsp.slot    = r_out.slot;
    assign o_rsp.tag_out = r_out.tag;
    assign o_rsp.last    = r_out.last;

endmodule

// ===== rtl/alarm_slot_table_top.sv =====
// Alarm slot table top level: front classifier, request queue and scanning back end.
// A rewrite passes through the queue register and is written to the slot table when the back end pops it;
// an arm scans from slot 0 for the first free slot; a tick scans one slot per cycle unless a new fire
// meets a stalled response output, and flushes its last fire from the pending register at the end.
// The back end takes no new request until its scan is done; the two-entry queue absorbs new requests.
// Synchronous active-low reset frees all slots and empties queue and response register.
module alarm_slot_table_top #(
    parameter int SLOT_COUNT = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ast_req_if.sink   i_req,
    ast_rsp_if.source o_rsp
);

    ast_pkg::t_req  push_data;
    ast_pkg::t_req  q_data;
    logic           q_push;
    logic           q_full;
    logic           q_vld;
    logic           q_pop;

    ast_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_req       (i_req),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (push_data)
    );

    ast_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (push_data),
        .o_data  (q_data),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_vld   (q_vld)
    );

    ast_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_q_data (q_data),
        .o_q_pop  (q_pop),
        .o_rsp    (o_rsp)
    );

endmodule
